// ===== src/csmm_pkg.sv =====
// Package: widths, pipeline geometry, word types and the carry-save round function.
`default_nettype none
package csmm_pkg;

   // operand and modulus width; the number of Montgomery rounds equals it
   localparam int WIDTH = 32;
   // rounds evaluated in one pipeline stage
   localparam int ROUNDS_PER_STAGE = 4;
   localparam int NUM_ROUND_STAGES = WIDTH / ROUNDS_PER_STAGE;
   // total 2*carry + sum needs two extra bits
   localparam int TOTAL_W = WIDTH + 2;

   // carry-save pair
   typedef struct packed {
      logic [WIDTH-1:0] sum;
      logic [WIDTH-1:0] carry;
   } csmm_cs_type;

   // word moving through the round stages
   typedef struct packed {
      csmm_cs_type      cs;
      logic [WIDTH-1:0] a;   // remaining multiplier bits, next one at bit 0
      logic [WIDTH-1:0] b;
   } csmm_stage_type;

   // One radix-2 round: add gated b, add modulus when odd, halve.
   function automatic csmm_cs_type csmm_round(input csmm_cs_type cs, input logic abit,
                                              input logic [WIDTH-1:0] b,
                                              input logic [WIDTH-1:0] m);
      logic [WIDTH-1:0] addend;
      logic [WIDTH-1:0] ca;
      logic [WIDTH-1:0] sa;
      logic [WIDTH-1:0] cb;
      logic [WIDTH-1:0] sb;
      logic [WIDTH-1:0] cc;
      logic [WIDTH-1:0] carry_sh;
      logic [WIDTH-1:0] sum1;
      logic [WIDTH-1:0] carry1;
      csmm_cs_type      res;
      // multiplicand add; carry shift drops the top bit
      addend   = abit ? b : '0;
      ca       = cs.sum & addend;
      sa       = cs.sum ^ addend;
      carry_sh = {cs.carry[WIDTH-2:0], 1'b0};
      cb       = carry_sh & sa;
      sum1     = carry_sh ^ sa;
      carry1   = ca | cb;
      // modulus add on odd sum, then halve
      addend    = sum1[0] ? m : '0;
      ca        = sum1 & addend;
      sa        = (sum1 ^ addend) >> 1;
      cb        = sa & ca;
      sb        = sa ^ ca;
      cc        = carry1 & sb;
      res.sum   = carry1 ^ sb;
      res.carry = cb | cc;
      return res;
   endfunction

endpackage
`default_nettype wire

// ===== src/csmm_round_stage.sv =====
// One pipeline stage evaluating ROUNDS_PER_STAGE carry-save Montgomery rounds.
`default_nettype none
module csmm_round_stage
   import csmm_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [WIDTH-1:0] modulus,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire csmm_stage_type   in_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output csmm_stage_type        out_data
);

   logic           valid_ff;
   csmm_stage_type data_ff;
   csmm_stage_type data_in;

   // chained rounds, multiplier bits consumed LSB first
   always_comb begin
      data_in = in_data;
      for (int i = 0; i < ROUNDS_PER_STAGE; i++) begin
         data_in.cs = csmm_round(data_in.cs, in_data.a[i], in_data.b, modulus);
      end
      data_in.a = in_data.a >> ROUNDS_PER_STAGE;
   end

   // stage advances when empty or when downstream takes the word
   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

// ===== src/csmm_final.sv =====
// Final two stages: carry-save resolve, then one conditional modulus subtract.
`default_nettype none
module csmm_final
   import csmm_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [WIDTH-1:0] modulus,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire csmm_cs_type      in_cs,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output logic [WIDTH-1:0]      out_product
);

   logic               total_valid_ff;
   logic [TOTAL_W-1:0] total_ff;
   logic [TOTAL_W-1:0] total_in;
   logic               total_ready;
   logic               res_valid_ff;
   logic [WIDTH-1:0]   res_ff;
   logic [WIDTH-1:0]   res_in;
   logic [TOTAL_W:0]   diff;

   // total = 2*carry + sum
   assign total_in = {1'b0, in_cs.carry, 1'b0} + {2'b00, in_cs.sum};
   assign in_ready = !total_valid_ff || total_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_valid_ff <= 1'b0;
      end else if (in_ready) begin
         total_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         total_ff <= total_in;
      end
   end

   // subtract once when total >= modulus (no borrow), keep low bits
   assign diff   = {1'b0, total_ff} - {3'b000, modulus};
   assign res_in = diff[TOTAL_W] ? total_ff[WIDTH-1:0] : diff[WIDTH-1:0];
   assign total_ready = !res_valid_ff || out_ready;

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
      end else if (total_ready) begin
         res_valid_ff <= total_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (total_ready && total_valid_ff) begin
         res_ff <= res_in;
      end
   end

   assign out_valid   = res_valid_ff;
   assign out_product = res_ff;

endmodule
`default_nettype wire

// ===== src/carry_save_montgomery_multiplier_core.sv =====
// Top level: carry-save radix-2 Montgomery multiplier with modulus register.
// Returns product = a*b*2^-32 mod modulus (one conditional subtract) for each
// input word. The pipeline is 8 stages of 4 carry-save rounds each, then a
// stage that forms 2*carry+sum and an output stage that subtracts the modulus
// once; it takes a new word every cycle unless the output stalls. The result
// is exact when both operands are below an odd modulus. The modulus register
// resets to 8380417 and should only be written while no word is in flight.
`default_nettype none
module carry_save_montgomery_multiplier_core
   import csmm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request words
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // [31:0] operand_a, [63:32] operand_b
   // result words
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [31:0] product
   // modulus register write
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_data     // [31:0] modulus
);

   localparam logic [WIDTH-1:0] MODULUS_RESET = WIDTH'(8380417);

   logic [WIDTH-1:0] modulus_ff;
   logic             stg_valid [NUM_ROUND_STAGES+1];
   logic             stg_ready [NUM_ROUND_STAGES+1];
   csmm_stage_type   stg_data  [NUM_ROUND_STAGES+1];

   // modulus register, always writable
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MODULUS_RESET;
      end else if (csr_valid) begin
         modulus_ff <= csr_data;
      end
   end

   // pipeline entry: zero carry-save pair
   assign stg_valid[0]      = req_tvalid;
   assign req_tready        = stg_ready[0];
   assign stg_data[0].cs    = '0;
   assign stg_data[0].a     = req_tdata[31:0];
   assign stg_data[0].b     = req_tdata[63:32];

   // round stages
   for (genvar s = 0; s < NUM_ROUND_STAGES; s++) begin : g_round
      csmm_round_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .modulus   (modulus_ff),
         .in_valid  (stg_valid[s]),
         .in_ready  (stg_ready[s]),
         .in_data   (stg_data[s]),
         .out_valid (stg_valid[s+1]),
         .out_ready (stg_ready[s+1]),
         .out_data  (stg_data[s+1])
      );
   end

   // resolve and reduce
   csmm_final u_final (
      .clock       (clock),
      .reset       (reset),
      .modulus     (modulus_ff),
      .in_valid    (stg_valid[NUM_ROUND_STAGES]),
      .in_ready    (stg_ready[NUM_ROUND_STAGES]),
      .in_cs       (stg_data[NUM_ROUND_STAGES].cs),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_product (rsp_tdata)
   );

endmodule
`default_nettype wire
